### design/owht_pkg.sv
// Shared widths, types and helper functions for the orthogonal wire hit test.
package owht_pkg;

    localparam int CW        = 20;          // coordinate width, Q.4
    localparam int PW        = CW + 1;      // route point width, Q.5
    localparam int DW        = CW + 2;      // signed point difference
    localparam int MW        = CW + 1;      // magnitude of a difference
    localparam int SW        = 2 * CW + 3;  // squared length / distance
    localparam int NSW       = 2 * CW + 4;  // signed dot product
    localparam int LO        = CW + 2;      // low slice of a split operand
    localparam int HI        = SW - LO;     // high slice of a split operand
    localparam int PLW       = LO + MW;
    localparam int PHW       = HI + MW;
    localparam int NW        = SW + MW;     // divider numerator
    localparam int QB        = MW;          // quotient bits, one per stage
    localparam int ZW        = 16;
    localparam int ZSQ       = 2 * ZW;
    localparam int TW        = 12;
    localparam int DLO       = LO + ZSQ;
    localparam int DHI       = HI + ZSQ;
    localparam int HW        = SW + ZSQ;
    localparam int RHS_SHIFT = 18;
    localparam int IW        = 3;           // register index width

    typedef enum logic [IW-1:0] {
        REG_START_X    = 3'd0,
        REG_START_Y    = 3'd1,
        REG_END_X      = 3'd2,
        REG_END_Y      = 3'd3,
        REG_HIT_TOL    = 3'd4,
        REG_STRAIGHT   = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PM_START,
        PM_END,
        PM_MID
    } proj_mode_t;

    typedef logic signed [PW-1:0] point_t;
    typedef logic signed [DW-1:0] diff_t;
    typedef logic [MW-1:0]        mag_t;
    typedef logic [SW-1:0]        dist_t;
    typedef logic [2*MW-1:0]      sq_t;

    typedef struct packed {
        point_t x;
        point_t y;
    } pt_t;

    typedef struct packed {
        mag_t x;
        mag_t y;
    } mpair_t;

    typedef struct packed {
        sq_t x;
        sq_t y;
    } sqpair_t;

    typedef struct packed {
        dist_t  d2;
        point_t px;
        point_t py;
    } cand_t;

    // per-query data carried down the pipe as far as the route select
    typedef struct packed {
        point_t          qx;
        point_t          qy;
        logic [ZSQ-1:0]  zsq;
        logic            straight;
        point_t          ax;
        point_t          ay;
        point_t          bx;
        point_t          by;
        point_t          mx;
    } base_t;

    typedef struct packed {
        base_t      b;
        diff_t      ux;
        diff_t      uy;
        diff_t      dx;
        diff_t      dy;
        pt_t [2:0]  cp;
    } s2_t;

    typedef struct packed {
        base_t              b;
        logic signed [NSW-1:0] pux;
        logic signed [NSW-1:0] puy;
        sq_t                sqx;
        sq_t                sqy;
        mag_t               dxm;
        mag_t               dym;
        logic               negx;
        logic               negy;
        pt_t [2:0]          cp;
        mpair_t [2:0]       tm;
    } s3_t;

    typedef struct packed {
        base_t              b;
        logic signed [NSW-1:0] n;
        dist_t              len2;
        mag_t               dxm;
        mag_t               dym;
        logic               negx;
        logic               negy;
        pt_t [2:0]          cp;
        sqpair_t [2:0]      ts;
    } s4_t;

    typedef struct packed {
        base_t          b;
        proj_mode_t     mode;
        dist_t          len2;
        logic           negx;
        logic           negy;
        logic [PLW-1:0] plx;
        logic [PHW-1:0] phx;
        logic [PLW-1:0] ply;
        logic [PHW-1:0] phy;
        pt_t [2:0]      cp;
        dist_t [2:0]    td;
    } s5_t;

    typedef struct packed {
        base_t          b;
        proj_mode_t     mode;
        dist_t          len2;
        logic           negx;
        logic           negy;
        dist_t          rx;
        dist_t          ry;
        logic [QB-1:0]  nx;
        logic [QB-1:0]  ny;
        logic [QB-1:0]  qtx;
        logic [QB-1:0]  qty;
        cand_t          alt;
    } div_t;

    typedef struct packed {
        base_t  b;
        cand_t  alt;
        point_t spx;
        point_t spy;
    } rnd_t;

    typedef struct packed {
        base_t  b;
        cand_t  alt;
        point_t spx;
        point_t spy;
        mpair_t am;
    } adf_t;

    typedef struct packed {
        base_t   b;
        cand_t   alt;
        point_t  spx;
        point_t  spy;
        sqpair_t sq;
    } asq_t;

    typedef struct packed {
        logic [ZSQ-1:0] zsq;
        cand_t          best;
    } sel_t;

    typedef struct packed {
        logic [DLO-1:0] plo;
        logic [DHI-1:0] phi;
        point_t         px;
        point_t         py;
    } hmul_t;

    typedef struct packed {
        dist_t r;
        logic  q;
    } dstep_t;

    function automatic mag_t mag_of(diff_t v);
        diff_t nv;
        nv = -v;
        return v[DW-1] ? nv[MW-1:0] : v[MW-1:0];
    endfunction

    // projection onto an axis-parallel segment a..b, zero length gives a
    function automatic point_t clamp_axis(point_t a, point_t b, point_t q);
        point_t r;
        if (a == b)
            r = a;
        else if (b > a)
            r = (q <= a) ? a : ((q >= b) ? b : q);
        else
            r = (q >= a) ? a : ((q <= b) ? b : q);
        return r;
    endfunction

    // one restoring division step
    function automatic dstep_t div_bit(dist_t r, logic nb, dist_t d);
        logic [SW:0] t;
        dstep_t      o;
        t = {r, nb};
        if (t >= {1'b0, d})
        begin
            t   = t - {1'b0, d};
            o.q = 1'b1;
        end
        else
        begin
            o.q = 1'b0;
        end
        o.r = t[SW-1:0];
        return o;
    endfunction

endpackage

### design/orthogonal_wire_hit_test_core.sv
// Top level: pipelined nearest-point and hit test against an orthogonal wire route.
//
//  channel | signals                                  | direction | moves
//  --------+------------------------------------------+-----------+-------------------------
//  query   | in_valid, in_ready, query_x/y, zoom       | in        | one query transaction
//  result  | out_valid, out_ready, hit, closest_x/y    | out       | one result transaction
//  config  | cfg_write, cfg_index, cfg_data            | in        | register write, no wait
//
// Fully pipelined: one query transaction can enter every cycle while the result
// side is not stalled. The pipeline length is set by the restoring divider, one
// quotient bit per stage over CW+1 stages, that projects onto a diagonal straight
// route.
// Reset clears all valid bits and loads the register defaults (tolerance and
// threshold 5.0, coordinates 0). Payload flops are not reset.
// A stall on the result side freezes every stage at once; in_ready follows the
// output register, so nothing is dropped or repeated.
module orthogonal_wire_hit_test_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [owht_pkg::CW-1:0] query_x,
    input  logic signed [owht_pkg::CW-1:0] query_y,
    input  logic [owht_pkg::ZW-1:0]       zoom,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          hit,
    output logic signed [owht_pkg::PW-1:0] closest_x,
    output logic signed [owht_pkg::PW-1:0] closest_y,
    input  logic                          cfg_write,
    input  logic [owht_pkg::IW-1:0]       cfg_index,
    input  logic [owht_pkg::CW-1:0]       cfg_data
);

    localparam int CW  = owht_pkg::CW;
    localparam int PW  = owht_pkg::PW;
    localparam int QB  = owht_pkg::QB;
    localparam int TW  = owht_pkg::TW;
    localparam int SW  = owht_pkg::SW;
    localparam int NW  = owht_pkg::NW;
    localparam int LO  = owht_pkg::LO;
    localparam int DW  = owht_pkg::DW;
    localparam int HW  = owht_pkg::HW;
    localparam int ZSQ = owht_pkg::ZSQ;

    // configuration registers
    logic [CW-1:0] start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [TW-1:0] hit_tol_reg, straight_thr_reg;
    logic [2*TW-1:0] tol_sq_reg;

    // pipeline registers
    owht_pkg::base_t  s1_reg, s1_next;
    owht_pkg::s2_t    s2_reg, s2_next;
    owht_pkg::s3_t    s3_reg, s3_next;
    owht_pkg::s4_t    s4_reg, s4_next;
    owht_pkg::s5_t    s5_reg, s5_next;
    owht_pkg::div_t   div_reg  [0:QB];
    owht_pkg::div_t   div_next [0:QB];
    owht_pkg::rnd_t   r_reg, r_next;
    owht_pkg::adf_t   a_reg, a_next;
    owht_pkg::asq_t   b_reg, b_next;
    owht_pkg::sel_t   c_reg, c_next;
    owht_pkg::hmul_t  d_reg, d_next;
    logic             hit_reg, hit_next;
    owht_pkg::point_t cx_reg, cy_reg;

    logic             v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [QB:0]      dv_reg;
    logic             vr_reg, va_reg, vb_reg, vc_reg, vd_reg, out_valid_reg;

    logic             adv;

    // whole pipe moves together; the output register frees itself when taken
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign closest_x = cx_reg;
    assign closest_y = cy_reg;

    // entry: route choice, Q.5 route points, zoom squared
    always_comb
    begin
        logic [CW:0]   ddx, ddy, ndx, ndy;
        logic [CW-1:0] mgx, mgy;
        ddx = {start_x_reg[CW-1], start_x_reg} - {end_x_reg[CW-1], end_x_reg};
        ddy = {start_y_reg[CW-1], start_y_reg} - {end_y_reg[CW-1], end_y_reg};
        ndx = -ddx;
        ndy = -ddy;
        mgx = ddx[CW] ? ndx[CW-1:0] : ddx[CW-1:0];
        mgy = ddy[CW] ? ndy[CW-1:0] : ddy[CW-1:0];
        s1_next.qx       = {query_x, 1'b0};
        s1_next.qy       = {query_y, 1'b0};
        s1_next.zsq      = ZSQ'(zoom) * ZSQ'(zoom);
        s1_next.straight = (mgx < CW'(straight_thr_reg)) || (mgy < CW'(straight_thr_reg));
        s1_next.ax       = {start_x_reg, 1'b0};
        s1_next.ay       = {start_y_reg, 1'b0};
        s1_next.bx       = {end_x_reg, 1'b0};
        s1_next.by       = {end_y_reg, 1'b0};
        s1_next.mx       = owht_pkg::point_t'($signed(start_x_reg))
                         + owht_pkg::point_t'($signed(end_x_reg));
    end

    // stage 2: straight-segment vectors; orthogonal segments project by clamping
    always_comb
    begin
        s2_next.b  = s1_reg;
        s2_next.ux = owht_pkg::diff_t'(s1_reg.qx) - owht_pkg::diff_t'(s1_reg.ax);
        s2_next.uy = owht_pkg::diff_t'(s1_reg.qy) - owht_pkg::diff_t'(s1_reg.ay);
        s2_next.dx = owht_pkg::diff_t'(s1_reg.bx) - owht_pkg::diff_t'(s1_reg.ax);
        s2_next.dy = owht_pkg::diff_t'(s1_reg.by) - owht_pkg::diff_t'(s1_reg.ay);
        s2_next.cp[0].x = owht_pkg::clamp_axis(s1_reg.ax, s1_reg.mx, s1_reg.qx);
        s2_next.cp[0].y = s1_reg.ay;
        s2_next.cp[1].x = s1_reg.mx;
        s2_next.cp[1].y = owht_pkg::clamp_axis(s1_reg.ay, s1_reg.by, s1_reg.qy);
        s2_next.cp[2].x = owht_pkg::clamp_axis(s1_reg.mx, s1_reg.bx, s1_reg.qx);
        s2_next.cp[2].y = s1_reg.by;
    end

    // stage 3: dot-product terms, squared lengths, distance components
    always_comb
    begin
        owht_pkg::mag_t dxm, dym;
        dxm = owht_pkg::mag_of(s2_reg.dx);
        dym = owht_pkg::mag_of(s2_reg.dy);
        s3_next.b    = s2_reg.b;
        s3_next.pux  = s2_reg.ux * s2_reg.dx;
        s3_next.puy  = s2_reg.uy * s2_reg.dy;
        s3_next.sqx  = dxm * dxm;
        s3_next.sqy  = dym * dym;
        s3_next.dxm  = dxm;
        s3_next.dym  = dym;
        s3_next.negx = s2_reg.dx[DW-1];
        s3_next.negy = s2_reg.dy[DW-1];
        s3_next.cp   = s2_reg.cp;
        for (int i = 0; i < 3; i++)
        begin
            s3_next.tm[i].x = owht_pkg::mag_of(owht_pkg::diff_t'(s2_reg.b.qx)
                                             - owht_pkg::diff_t'(s2_reg.cp[i].x));
            s3_next.tm[i].y = owht_pkg::mag_of(owht_pkg::diff_t'(s2_reg.b.qy)
                                             - owht_pkg::diff_t'(s2_reg.cp[i].y));
        end
    end

    // stage 4: n = u.d, len2 = |d|^2, squared components
    always_comb
    begin
        s4_next.b    = s3_reg.b;
        s4_next.n    = s3_reg.pux + s3_reg.puy;
        s4_next.len2 = SW'(s3_reg.sqx) + SW'(s3_reg.sqy);
        s4_next.dxm  = s3_reg.dxm;
        s4_next.dym  = s3_reg.dym;
        s4_next.negx = s3_reg.negx;
        s4_next.negy = s3_reg.negy;
        s4_next.cp   = s3_reg.cp;
        for (int i = 0; i < 3; i++)
        begin
            s4_next.ts[i].x = s3_reg.tm[i].x * s3_reg.tm[i].x;
            s4_next.ts[i].y = s3_reg.tm[i].y * s3_reg.tm[i].y;
        end
    end

    // stage 5: clamp decision; n*|d| split into two partial products
    always_comb
    begin
        logic [SW-1:0] nm;
        nm = s4_reg.n[SW-1:0];
        if (s4_reg.len2 == '0 || s4_reg.n[owht_pkg::NSW-1] || s4_reg.n == '0)
            s5_next.mode = owht_pkg::PM_START;
        else if ($unsigned(s4_reg.n) >= {1'b0, s4_reg.len2})
            s5_next.mode = owht_pkg::PM_END;
        else
            s5_next.mode = owht_pkg::PM_MID;
        s5_next.b    = s4_reg.b;
        s5_next.len2 = s4_reg.len2;
        s5_next.negx = s4_reg.negx;
        s5_next.negy = s4_reg.negy;
        s5_next.plx  = nm[LO-1:0] * s4_reg.dxm;
        s5_next.phx  = nm[SW-1:LO] * s4_reg.dxm;
        s5_next.ply  = nm[LO-1:0] * s4_reg.dym;
        s5_next.phy  = nm[SW-1:LO] * s4_reg.dym;
        s5_next.cp   = s4_reg.cp;
        for (int i = 0; i < 3; i++)
            s5_next.td[i] = SW'(s4_reg.ts[i].x) + SW'(s4_reg.ts[i].y);
    end

    // divider load: numerators, nearest orthogonal segment (first wins ties);
    // divider: one quotient bit per stage for each axis
    always_comb
    begin
        logic [NW-1:0] numx, numy;
        owht_pkg::cand_t best;
        owht_pkg::dstep_t sx, sy;
        numx = (NW'(s5_reg.phx) << LO) + NW'(s5_reg.plx);
        numy = (NW'(s5_reg.phy) << LO) + NW'(s5_reg.ply);
        best.d2 = s5_reg.td[0];
        best.px = s5_reg.cp[0].x;
        best.py = s5_reg.cp[0].y;
        for (int i = 1; i < 3; i++)
        begin
            if (s5_reg.td[i] < best.d2)
            begin
                best.d2 = s5_reg.td[i];
                best.px = s5_reg.cp[i].x;
                best.py = s5_reg.cp[i].y;
            end
        end
        div_next[0].b    = s5_reg.b;
        div_next[0].mode = s5_reg.mode;
        div_next[0].len2 = s5_reg.len2;
        div_next[0].negx = s5_reg.negx;
        div_next[0].negy = s5_reg.negy;
        div_next[0].rx   = numx[NW-1:QB];
        div_next[0].ry   = numy[NW-1:QB];
        div_next[0].nx   = numx[QB-1:0];
        div_next[0].ny   = numy[QB-1:0];
        div_next[0].qtx  = '0;
        div_next[0].qty  = '0;
        div_next[0].alt  = best;
        for (int k = 0; k < QB; k++)
        begin
            sx = owht_pkg::div_bit(div_reg[k].rx, div_reg[k].nx[QB-1], div_reg[k].len2);
            sy = owht_pkg::div_bit(div_reg[k].ry, div_reg[k].ny[QB-1], div_reg[k].len2);
            div_next[k+1]     = div_reg[k];
            div_next[k+1].rx  = sx.r;
            div_next[k+1].ry  = sy.r;
            div_next[k+1].nx  = div_reg[k].nx << 1;
            div_next[k+1].ny  = div_reg[k].ny << 1;
            div_next[k+1].qtx = {div_reg[k].qtx[QB-2:0], sx.q};
            div_next[k+1].qty = {div_reg[k].qty[QB-2:0], sy.q};
        end
    end

    // round half away from the start point, apply sign, pick clamp result
    always_comb
    begin
        owht_pkg::div_t  dq;
        owht_pkg::diff_t offx, offy, sox, soy, pxw, pyw;
        dq   = div_reg[QB];
        offx = {1'b0, dq.qtx} + DW'({dq.rx, 1'b0} >= {1'b0, dq.len2});
        offy = {1'b0, dq.qty} + DW'({dq.ry, 1'b0} >= {1'b0, dq.len2});
        sox  = dq.negx ? -offx : offx;
        soy  = dq.negy ? -offy : offy;
        pxw  = owht_pkg::diff_t'(dq.b.ax) + sox;
        pyw  = owht_pkg::diff_t'(dq.b.ay) + soy;
        r_next.b   = dq.b;
        r_next.alt = dq.alt;
        case (dq.mode)
            owht_pkg::PM_START:
            begin
                r_next.spx = dq.b.ax;
                r_next.spy = dq.b.ay;
            end
            owht_pkg::PM_END:
            begin
                r_next.spx = dq.b.bx;
                r_next.spy = dq.b.by;
            end
            default:
            begin
                r_next.spx = pxw[PW-1:0];
                r_next.spy = pyw[PW-1:0];
            end
        endcase
    end

    // straight-route distance: difference, square, sum
    always_comb
    begin
        a_next.b    = r_reg.b;
        a_next.alt  = r_reg.alt;
        a_next.spx  = r_reg.spx;
        a_next.spy  = r_reg.spy;
        a_next.am.x = owht_pkg::mag_of(owht_pkg::diff_t'(r_reg.b.qx)
                                     - owht_pkg::diff_t'(r_reg.spx));
        a_next.am.y = owht_pkg::mag_of(owht_pkg::diff_t'(r_reg.b.qy)
                                     - owht_pkg::diff_t'(r_reg.spy));
    end

    always_comb
    begin
        b_next.b    = a_reg.b;
        b_next.alt  = a_reg.alt;
        b_next.spx  = a_reg.spx;
        b_next.spy  = a_reg.spy;
        b_next.sq.x = a_reg.am.x * a_reg.am.x;
        b_next.sq.y = a_reg.am.y * a_reg.am.y;
    end

    // route select
    always_comb
    begin
        c_next.zsq = b_reg.b.zsq;
        if (b_reg.b.straight)
        begin
            c_next.best.d2 = SW'(b_reg.sq.x) + SW'(b_reg.sq.y);
            c_next.best.px = b_reg.spx;
            c_next.best.py = b_reg.spy;
        end
        else
        begin
            c_next.best = b_reg.alt;
        end
    end

    // D^2 * Z^2 as two partial products, then the compare against T^2 << 18
    always_comb
    begin
        d_next.plo = c_reg.best.d2[LO-1:0] * c_reg.zsq;
        d_next.phi = c_reg.best.d2[SW-1:LO] * c_reg.zsq;
        d_next.px  = c_reg.best.px;
        d_next.py  = c_reg.best.py;
    end

    always_comb
    begin
        logic [HW-1:0] lhs, rhs;
        lhs      = (HW'(d_reg.phi) << LO) + HW'(d_reg.plo);
        rhs      = HW'(tol_sq_reg) << owht_pkg::RHS_SHIFT;
        hit_next = lhs < rhs;
    end

    // control: valid bits and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg           <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            v5_reg           <= 1'b0;
            dv_reg           <= '0;
            vr_reg           <= 1'b0;
            va_reg           <= 1'b0;
            vb_reg           <= 1'b0;
            vc_reg           <= 1'b0;
            vd_reg           <= 1'b0;
            out_valid_reg    <= 1'b0;
            start_x_reg      <= '0;
            start_y_reg      <= '0;
            end_x_reg        <= '0;
            end_y_reg        <= '0;
            hit_tol_reg      <= TW'(80);
            straight_thr_reg <= TW'(80);
        end
        else
        begin
            if (adv)
            begin
                v1_reg        <= in_valid;
                v2_reg        <= v1_reg;
                v3_reg        <= v2_reg;
                v4_reg        <= v3_reg;
                v5_reg        <= v4_reg;
                dv_reg        <= {dv_reg[QB-1:0], v5_reg};
                vr_reg        <= dv_reg[QB];
                va_reg        <= vr_reg;
                vb_reg        <= va_reg;
                vc_reg        <= vb_reg;
                vd_reg        <= vc_reg;
                out_valid_reg <= vd_reg;
            end
            if (cfg_write)
            begin
                case (cfg_index)
                    owht_pkg::REG_START_X:  start_x_reg      <= cfg_data;
                    owht_pkg::REG_START_Y:  start_y_reg      <= cfg_data;
                    owht_pkg::REG_END_X:    end_x_reg        <= cfg_data;
                    owht_pkg::REG_END_Y:    end_y_reg        <= cfg_data;
                    owht_pkg::REG_HIT_TOL:  hit_tol_reg      <= cfg_data[TW-1:0];
                    owht_pkg::REG_STRAIGHT: straight_thr_reg <= cfg_data[TW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        tol_sq_reg <= hit_tol_reg * hit_tol_reg;
        if (adv)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
            s3_reg <= s3_next;
            s4_reg <= s4_next;
            s5_reg <= s5_next;
            for (int k = 0; k <= QB; k++)
                div_reg[k] <= div_next[k];
            r_reg   <= r_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
            c_reg   <= c_next;
            d_reg   <= d_next;
            hit_reg <= hit_next;
            cx_reg  <= d_reg.px;
            cy_reg  <= d_reg.py;
        end
    end

endmodule
